// File: design/command_line_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the command line tokenizer
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS
// Check that holds at every clock edge outside reset
`define CLT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check with a non-overlapping implication from antecedent to consequent
`define CLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CLT_ASSERT(lbl, prop, msg)
`define CLT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: design/cmdtok_pkg.sv
// ----------------------------------------------------------------------------
// cmdtok_pkg
// Beat types, byte codes and status codes of the command line tokenizer.
// ----------------------------------------------------------------------------
package cmdtok_pkg;

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;

    // Token count saturates here; fewer than this is an error
    localparam logic [1:0] MIN_TOKENS = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNCLOSED = 2'd1;
    localparam logic [1:0] ST_TOO_FEW  = 2'd2;
    localparam logic [1:0] ST_NO_SEMI  = 2'd3;

    typedef struct packed {
        logic [7:0] in_char;
        logic       is_last;
    } req_beat_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       token_start;
        logic       done_res;
        logic [1:0] status;
    } tok_beat_t;

    typedef struct packed {
        logic       in_quote;
        logic       token_open;
        logic [1:0] token_count;
        logic       last_is_semicolon;
    } lex_state_t;

endpackage

// File: design/cmdtok_in_reg.sv
// ----------------------------------------------------------------------------
// cmdtok_in_reg
// Input register stage: captures one request byte per cycle while the held beat can move on.
// ----------------------------------------------------------------------------
module cmdtok_in_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  cmdtok_pkg::req_beat_t  req,
    input  logic                   advance,
    output logic                   s1_valid,
    output cmdtok_pkg::req_beat_t  s1_beat
);
    import cmdtok_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    req_beat_t beat_reg;

    // Take a new beat when empty or when the held beat moves on this cycle
    assign req_ready  = !valid_reg || advance;
    assign valid_next = req_ready ? req_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            beat_reg <= req;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_beat  = beat_reg;

endmodule

// File: design/cmdtok_lexer.sv
// ----------------------------------------------------------------------------
// cmdtok_lexer
// Lexer state and per-byte classification, token marking and final status.
// ----------------------------------------------------------------------------
module cmdtok_lexer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  cmdtok_pkg::req_beat_t  s1_beat,
    output cmdtok_pkg::tok_beat_t  res
);
    import cmdtok_pkg::*;

    lex_state_t state_reg;
    lex_state_t state_next;
    lex_state_t upd;
    logic       keep;
    logic       start;
    logic       begin_tok;
    logic       begin_semi;
    logic [7:0] c;
    logic [1:0] status;

    assign c = s1_beat.in_char;

    always_comb
    begin
        upd        = state_reg;
        keep       = 1'b0;
        start      = 1'b0;
        begin_tok  = 1'b0;
        begin_semi = 1'b0;

        priority if (c == CHAR_QUOTE)
        begin
            keep = 1'b1;
            if (state_reg.in_quote)
            begin
                upd.token_open = 1'b0;
            end
            else
            begin
                start          = 1'b1;
                upd.token_open = 1'b1;
                begin_tok      = 1'b1;
            end
            upd.in_quote = !state_reg.in_quote;
        end
        else if (state_reg.in_quote)
        begin
            keep = 1'b1;
        end
        else if (c == CHAR_SPACE || c == CHAR_CR || c == CHAR_LF)
        begin
            // drop the separator and close the open token
            upd.token_open = 1'b0;
        end
        else if (c == CHAR_COMMA || c == CHAR_SEMI)
        begin
            keep           = 1'b1;
            start          = 1'b1;
            upd.token_open = 1'b0;
            begin_tok      = 1'b1;
            begin_semi     = (c == CHAR_SEMI);
        end
        else
        begin
            keep = 1'b1;
            if (!state_reg.token_open)
            begin
                start          = 1'b1;
                upd.token_open = 1'b1;
                begin_tok      = 1'b1;
            end
        end

        if (begin_tok)
        begin
            if (state_reg.token_count < MIN_TOKENS)
            begin
                upd.token_count = state_reg.token_count + 2'd1;
            end
            upd.last_is_semicolon = begin_semi;
        end
    end

    always_comb
    begin
        status = ST_OK;
        if (s1_beat.is_last)
        begin
            priority if (upd.in_quote)
            begin
                status = ST_UNCLOSED;
            end
            else if (upd.token_count < MIN_TOKENS)
            begin
                status = ST_TOO_FEW;
            end
            else if (!upd.last_is_semicolon)
            begin
                status = ST_NO_SEMI;
            end
            else
            begin
                status = ST_OK;
            end
        end
    end

    // Return to the reset state after the final byte of a request
    assign state_next = s1_beat.is_last ? lex_state_t'('0) : upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    assign res.out_char    = keep ? c : 8'h00;
    assign res.char_valid  = keep;
    assign res.token_start = start;
    assign res.done_res    = s1_beat.is_last;
    assign res.status      = status;

endmodule

// File: design/cmdtok_out_reg.sv
// ----------------------------------------------------------------------------
// cmdtok_out_reg
// Result register: holds one token beat until the consumer takes it.
// ----------------------------------------------------------------------------
module cmdtok_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load_valid,
    input  cmdtok_pkg::tok_beat_t  load_beat,
    output logic                   take,
    output logic                   tok_valid,
    input  logic                   tok_ready,
    output cmdtok_pkg::tok_beat_t  tok
);
    import cmdtok_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    tok_beat_t beat_reg;

    assign take       = !valid_reg || tok_ready;
    assign valid_next = take ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && take)
        begin
            beat_reg <= load_beat;
        end
    end

    assign tok_valid = valid_reg;
    assign tok       = beat_reg;

endmodule

// File: design/command_line_tokenizer.sv
// Data path: a request byte accepted into the input register is loaded into the result
// register once that register can take it, and is offered on tok from then on.
// Throughput: one byte per cycle while the consumer keeps up; the lexer state updates as a byte moves from
// the input register into the result register.
// A stalled consumer holds the result register and backs up through the input register.
// Reset (rst_n low, asynchronous) empties both registers and clears the lexer state.
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Byte-serial request lexer with token start marks and end-of-request status.
// ----------------------------------------------------------------------------
module command_line_tokenizer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  cmdtok_pkg::req_beat_t  req,
    output logic                   tok_valid,
    input  logic                   tok_ready,
    output cmdtok_pkg::tok_beat_t  tok
);
    import cmdtok_pkg::*;

    logic      s1_valid;
    req_beat_t s1_beat;
    tok_beat_t res;
    logic      take;
    logic      fire;

    assign fire = s1_valid && take;

    cmdtok_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .advance   (take),
        .s1_valid  (s1_valid),
        .s1_beat   (s1_beat)
    );

    cmdtok_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .s1_beat (s1_beat),
        .res     (res)
    );

    cmdtok_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (s1_valid),
        .load_beat  (res),
        .take       (take),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok        (tok)
    );

`include "command_line_tokenizer_assert.svh"

    // A dropped separator carries no byte and no start mark
    `CLT_ASSERT(a_drop_clean, !(tok_valid && !tok.char_valid) || (!tok.token_start && tok.out_char == 8'h00), "dropped beat carries data")
    // Status only on the final byte of a request
    `CLT_ASSERT(a_status_done, !(tok_valid && !tok.done_res) || tok.status == ST_OK, "status outside final beat")
    // Back-pressure only when both registers are full and the consumer stalls
    `CLT_ASSERT(a_ready_full, req_ready || (s1_valid && tok_valid && !tok_ready), "input stalled with room")
    // A byte held in the input register moves on once the consumer frees the result register
    `CLT_ASSERT_NEXT(a_advance, s1_valid && tok_ready, tok_valid, "held byte did not advance")

endmodule

// File: tb/command_line_tokenizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer_checker
// Watches both channels of the tokenizer. Each accepted request byte is run
// through a local lexer model and the predicted beat is queued; each accepted
// result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module command_line_tokenizer_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_ready,
    input  cmdtok_pkg::req_beat_t  req,
    input  logic                   tok_valid,
    input  logic                   tok_ready,
    input  cmdtok_pkg::tok_beat_t  tok,
    output int                     fails,
    output int                     outstanding
);
    import cmdtok_pkg::*;

    lex_state_t lex = '0;
    tok_beat_t  predicted_tok_q[$];

    function automatic void open_token(input logic is_semi);
        if (lex.token_count < MIN_TOKENS)
            lex.token_count = lex.token_count + 2'd1;
        lex.last_is_semicolon = is_semi;
    endfunction

    // Advance the lexer by one byte and return the beat it should produce
    function automatic tok_beat_t lex_byte(input req_beat_t b);
        tok_beat_t r;
        r = '0;
        if (b.in_char == CHAR_QUOTE)
        begin
            r.char_valid = 1'b1;
            if (lex.in_quote)
            begin
                lex.token_open = 1'b0;
            end
            else
            begin
                r.token_start  = 1'b1;
                lex.token_open = 1'b1;
                open_token(1'b0);
            end
            lex.in_quote = !lex.in_quote;
        end
        else if (lex.in_quote)
        begin
            r.char_valid = 1'b1;
        end
        else if (b.in_char == CHAR_SPACE || b.in_char == CHAR_CR || b.in_char == CHAR_LF)
        begin
            lex.token_open = 1'b0;
        end
        else if (b.in_char == CHAR_COMMA || b.in_char == CHAR_SEMI)
        begin
            r.char_valid   = 1'b1;
            r.token_start  = 1'b1;
            lex.token_open = 1'b0;
            open_token(b.in_char == CHAR_SEMI);
        end
        else
        begin
            r.char_valid = 1'b1;
            if (!lex.token_open)
            begin
                r.token_start  = 1'b1;
                lex.token_open = 1'b1;
                open_token(1'b0);
            end
        end

        if (r.char_valid)
            r.out_char = b.in_char;

        if (b.is_last)
        begin
            r.done_res = 1'b1;
            if (lex.in_quote)
                r.status = ST_UNCLOSED;
            else if (lex.token_count < MIN_TOKENS)
                r.status = ST_TOO_FEW;
            else if (!lex.last_is_semicolon)
                r.status = ST_NO_SEMI;
            else
                r.status = ST_OK;
            // a finished request leaves the lexer as after reset
            lex = '0;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        tok_beat_t want;
        tok_beat_t fresh;
        if (rst_n)
        begin
            if (tok_valid && tok_ready)
            begin
                if (predicted_tok_q.size() == 0)
                begin
                    fails <= fails + 1;
                    if (fails < 10)
                        $display("%0t: tok beat with nothing predicted: %02h/%0b/%0b/%0b/%0d",
                                 $realtime, tok.out_char, tok.char_valid, tok.token_start,
                                 tok.done_res, tok.status);
                end
                else
                begin
                    want = predicted_tok_q.pop_front();
                    if (tok.out_char !== want.out_char || tok.char_valid !== want.char_valid ||
                        tok.token_start !== want.token_start ||
                        tok.done_res !== want.done_res || tok.status !== want.status)
                    begin
                        fails <= fails + 1;
                        if (fails < 10)
                            $display({"%0t: tok mismatch (char/valid/start/done/status): ",
                                      "expected %02h/%0b/%0b/%0b/%0d, got %02h/%0b/%0b/%0b/%0d"},
                                     $realtime, want.out_char, want.char_valid,
                                     want.token_start, want.done_res, want.status,
                                     tok.out_char, tok.char_valid, tok.token_start,
                                     tok.done_res, tok.status);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                fresh = lex_byte(req);
                predicted_tok_q = {predicted_tok_q, fresh};
            end
            outstanding <= predicted_tok_q.size();
        end
    end

endmodule

// File: tb/tb_command_line_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_line_tokenizer
// Drives request strings into the tokenizer: a handful of directed strings
// for each status and separator case, then random well-formed requests mixed
// with noise, over phases of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_command_line_tokenizer;
    import cmdtok_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int BYTES_PER_PHASE = 280;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_beat_t req = '0;
    logic      tok_valid;
    logic      tok_ready = 1'b0;
    tok_beat_t tok;

    int fails;
    int outstanding;
    int cycles = 0;
    int sent = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    logic [7:0] line_q[$];

    always #1 clk = ~clk;

    command_line_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

    command_line_tokenizer_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .tok_valid   (tok_valid),
        .tok_ready   (tok_ready),
        .tok         (tok),
        .fails       (fails),
        .outstanding (outstanding)
    );

    always @(posedge clk)
        tok_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] c, input logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req <= '{in_char: c, is_last: last};
        do
            @(posedge clk);
        while (!req_ready);
        sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++)
            send_beat(line_q[i], i == line_q.size() - 1);
    endtask

    // Append one byte to the request being built
    function automatic void add_byte(input logic [7:0] b);
        line_q = {line_q, b};
    endfunction

    function automatic logic [7:0] sep_byte();
        case ($urandom_range(2))
            0:       return CHAR_SPACE;
            1:       return CHAR_CR;
            default: return CHAR_LF;
        endcase
    endfunction

    // Any nonzero byte that the lexer treats as plain token text
    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CHAR_QUOTE || c == CHAR_SPACE || c == CHAR_CR || c == CHAR_LF ||
               c == CHAR_COMMA || c == CHAR_SEMI);
        return c;
    endfunction

    task automatic build_request();
        int ntok;
        int n;
        logic [7:0] c;
        line_q.delete();
        if ($urandom_range(99) < 78)
        begin
            ntok = $urandom_range(1, 5);
            for (int t = 0; t < ntok; t++)
            begin
                if ($urandom_range(2) == 0)
                    repeat ($urandom_range(1, 2)) add_byte(sep_byte());
                case ($urandom_range(5))
                    2:
                    begin
                        add_byte(CHAR_QUOTE);
                        repeat ($urandom_range(0, 4))
                        begin
                            c = 8'($urandom_range(1, 255));
                            add_byte(c == CHAR_QUOTE ? CHAR_SPACE : c);
                        end
                        add_byte(CHAR_QUOTE);
                    end
                    3:       add_byte(CHAR_COMMA);
                    4:       add_byte(CHAR_SEMI);
                    default: repeat ($urandom_range(1, 4)) add_byte(word_byte());
                endcase
            end
            if ($urandom_range(9) != 0)
                add_byte(CHAR_SEMI);
            if ($urandom_range(3) == 0)
                add_byte(sep_byte());
            // now and then leave a quote hanging
            if ($urandom_range(19) == 0)
            begin
                add_byte(CHAR_QUOTE);
                repeat ($urandom_range(0, 2)) add_byte(word_byte());
            end
        end
        else
        begin
            n = $urandom_range(1, 10);
            repeat (n)
            begin
                case ($urandom_range(8))
                    0:       add_byte(CHAR_QUOTE);
                    1:       add_byte(CHAR_COMMA);
                    2:       add_byte(CHAR_SEMI);
                    3:       add_byte(sep_byte());
                    default: add_byte(8'($urandom_range(1, 255)));
                endcase
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings: bytes 01 and FF, every separator and each status
        line_q = '{8'h01};
        send_line();
        line_q = '{8'h61, CHAR_QUOTE, 8'h62};
        send_line();
        line_q = '{8'hFF, CHAR_CR, CHAR_LF, CHAR_SEMI};
        send_line();
        line_q = '{CHAR_QUOTE, 8'h71, CHAR_QUOTE, CHAR_COMMA};
        send_line();
        line_q = '{CHAR_SPACE};
        send_line();
        line_q = '{8'h61, CHAR_SPACE, CHAR_SEMI};
        send_line();
        line_q = '{CHAR_QUOTE, CHAR_SEMI, CHAR_SPACE, CHAR_QUOTE, CHAR_SEMI};
        send_line();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 60;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 60;
                end
                default:
                begin
                    send_idle_pct = 34;
                    stall_pct     = 34;
                end
            endcase
            n_loop:
            begin
                int target;
                target = sent + BYTES_PER_PHASE;
                while (sent < target)
                begin
                    build_request();
                    send_line();
                end
            end
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (fails == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
